// ----- design/ris_pkg.sv -----
package ris_pkg;

  // Channel count; the input word carries one sample field per channel
  localparam int CHANNELS = 8;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int CNT_W    = $clog2(CHANNELS + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int KNOB_W   = 12;
  localparam int GAIN_W   = 17;
  localparam int FADE_W   = 17;
  localparam int BLINK_W  = 14;
  localparam int RAND_W   = 16;

  // Fixed-point constants
  localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(65536);
  localparam logic [BLINK_W-1:0] BLINK_FULL = BLINK_W'(10000);
  localparam int                 FADE_SHIFT = 27;

  // Mix datapath widths
  localparam int TERM_W = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W  = SAMPLE_W + GAIN_W + CH_W;
  localparam int PROD_W = ACC_W + FADE_W;
  localparam int MIX_W  = PROD_W - FADE_SHIFT + 1;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_KNOB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_HIGH = 2'd3;

  typedef struct packed {
    logic [KNOB_W-1:0]   fade_knob;
    logic [GAIN_W-1:0]   decay_multiplier;
    logic [SAMPLE_W-1:0] gate_low_threshold;
    logic [SAMPLE_W-1:0] gate_high_threshold;
  } ris_cfg_t;

  // Classified word handed from the front to the mix engine
  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_W-1:0] samples;
    logic [FADE_W-1:0]                 fade;
    logic [CH_W-1:0]                   active;
    logic [BLINK_W-1:0]                blink;
    logic                              fired;
    logic                              any_conn;
  } ris_item_t;

endpackage

// ----- design/ris_if.sv -----
interface ris_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_0;
  logic signed [15:0] sample_1;
  logic signed [15:0] sample_2;
  logic signed [15:0] sample_3;
  logic signed [15:0] sample_4;
  logic signed [15:0] sample_5;
  logic signed [15:0] sample_6;
  logic signed [15:0] sample_7;
  logic [7:0]         connected_mask;
  logic signed [15:0] gate_level;
  logic signed [15:0] fade_control;
  logic [15:0]        random_word;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           sample_6, sample_7, connected_mask, gate_level, fade_control, random_word,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           sample_6, sample_7, connected_mask, gate_level, fade_control, random_word,
    output ready
  );
endinterface

interface ris_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  logic [2:0]         selected_channel;
  logic [13:0]        blink_level;
  logic               trigger_fired;

  modport source (
    output valid, mixed_sample, selected_channel, blink_level, trigger_fired,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, selected_channel, blink_level, trigger_fired,
    output ready
  );
endinterface

// ----- design/ris_front.sv -----
module ris_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ris_in_if.sink           in_ch,
  input  ris_pkg::ris_cfg_t cfg_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output ris_pkg::ris_item_t item_o
);

  logic                              gate_high_q, gate_high_d;
  logic [ris_pkg::CH_W-1:0]          active_q, active_d;
  logic [ris_pkg::BLINK_W-1:0]       blink_q, blink_d;
  logic                              accept;
  logic                              fired;
  logic [ris_pkg::CHANNELS-1:0]      mask;
  logic [ris_pkg::CNT_W-1:0]         count;
  logic [ris_pkg::CNT_W-1:0]         pre;
  logic [ris_pkg::RAND_W+ris_pkg::CNT_W-1:0] pick;
  logic [ris_pkg::CNT_W-1:0]         k;
  logic                              hit;
  logic signed [ris_pkg::FADE_W-1:0] fade;

  assign accept       = in_ch.valid && push_ready_i;
  assign in_ch.ready  = push_ready_i;
  assign push_valid_o = in_ch.valid;
  assign mask         = in_ch.connected_mask;

  // Schmitt trigger on the gate
  always_comb begin
    gate_high_d = gate_high_q;
    fired       = 1'b0;
    if (gate_high_q) begin
      if (in_ch.gate_level <= $signed(cfg_i.gate_low_threshold)) gate_high_d = 1'b0;
    end else if (in_ch.gate_level >= $signed(cfg_i.gate_high_threshold)) begin
      gate_high_d = 1'b1;
      fired       = 1'b1;
    end
  end

  // Count connected channels and pick the k-th one on a firing
  always_comb begin
    count = '0;
    for (int i = 0; i < ris_pkg::CHANNELS; i++) begin
      count = count + ris_pkg::CNT_W'(mask[i]);
    end
    pick = (ris_pkg::RAND_W + ris_pkg::CNT_W)'(in_ch.random_word)
         * (ris_pkg::RAND_W + ris_pkg::CNT_W)'(count);
    k    = pick[ris_pkg::RAND_W +: ris_pkg::CNT_W];
    pre      = '0;
    hit      = 1'b0;
    active_d = active_q;
    blink_d  = blink_q;
    if (count != '0) begin
      if (fired) begin
        for (int i = 0; i < ris_pkg::CHANNELS; i++) begin
          if (mask[i]) begin
            if (!hit && pre == k) begin
              active_d = ris_pkg::CH_W'(i);
              hit      = 1'b1;
            end
            pre = pre + 1'b1;
          end
        end
        blink_d = ris_pkg::BLINK_FULL;
      end else if (blink_q != '0) begin
        blink_d = blink_q - 1'b1;
      end
    end
  end

  // Fade amount: knob plus control voltage, Q11
  assign fade = $signed({{(ris_pkg::FADE_W-ris_pkg::KNOB_W){1'b0}}, cfg_i.fade_knob})
              + ris_pkg::FADE_W'(in_ch.fade_control);

  // Build the word for the mix engine
  always_comb begin
    item_o.samples[0] = in_ch.sample_0;
    item_o.samples[1] = in_ch.sample_1;
    item_o.samples[2] = in_ch.sample_2;
    item_o.samples[3] = in_ch.sample_3;
    item_o.samples[4] = in_ch.sample_4;
    item_o.samples[5] = in_ch.sample_5;
    item_o.samples[6] = in_ch.sample_6;
    item_o.samples[7] = in_ch.sample_7;
    item_o.fade       = fade;
    item_o.active     = active_d;
    item_o.blink      = blink_d;
    item_o.fired      = fired;
    item_o.any_conn   = (count != '0);
  end

  // Advance front state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_high_q <= 1'b1;
      active_q    <= '0;
      blink_q     <= '0;
    end else if (accept) begin
      gate_high_q <= gate_high_d;
      active_q    <= active_d;
      blink_q     <= blink_d;
    end
  end

endmodule

// ----- design/ris_queue.sv -----
module ris_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  ris_pkg::ris_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output ris_pkg::ris_item_t pop_item_o
);

  ris_pkg::ris_item_t           mem_q [ris_pkg::QDEPTH];
  logic [ris_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [ris_pkg::QCNT_W-1:0]   cnt_q;
  logic                         push, pop;

  assign push_ready_o = (cnt_q != ris_pkg::QCNT_W'(ris_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Hold words in arrival order
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == ris_pkg::QPTR_W'(ris_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == ris_pkg::QPTR_W'(ris_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- design/ris_back.sv -----
module ris_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ris_pkg::ris_cfg_t  cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  ris_pkg::ris_item_t pop_item_i,
  ris_out_if.source          out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECAY, S_TERM, S_ACC, S_FADE, S_MIX, S_OUT
  } state_e;

  localparam logic signed [ris_pkg::MIX_W-1:0] SAT_HI = ris_pkg::MIX_W'(32767);
  localparam logic signed [ris_pkg::MIX_W-1:0] SAT_LO = -ris_pkg::MIX_W'(32768);

  state_e                                state_q;
  ris_pkg::ris_item_t                    item_q;
  logic [ris_pkg::CH_W-1:0]              ch_q;
  logic [ris_pkg::GAIN_W-1:0]            gain_q [ris_pkg::CHANNELS];
  logic [2*ris_pkg::GAIN_W-1:0]          prod_q;
  logic signed [ris_pkg::TERM_W-1:0]     term_q;
  logic signed [ris_pkg::ACC_W-1:0]      acc_q;
  logic signed [ris_pkg::PROD_W-1:0]     scaled_q;
  logic signed [ris_pkg::SAMPLE_W-1:0]   held_q;

  logic                                  out_valid_q;
  logic signed [ris_pkg::SAMPLE_W-1:0]   out_mix_q;
  logic [ris_pkg::CH_W-1:0]              out_sel_q;
  logic [ris_pkg::BLINK_W-1:0]           out_blink_q;
  logic                                  out_fired_q;

  logic [ris_pkg::GAIN_W:0]              decayed;
  logic [ris_pkg::GAIN_W-1:0]            gcap;
  logic signed [ris_pkg::SAMPLE_W-1:0]   ch_sample;
  logic signed [ris_pkg::SAMPLE_W-1:0]   act_sample;
  logic signed [ris_pkg::MIX_W-1:0]      mix;
  logic signed [ris_pkg::SAMPLE_W-1:0]   mix_sat;
  logic                                  out_free;

  assign pop_ready_o = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ch.ready;

  // Decayed gain, capped at unity
  assign decayed   = prod_q[2*ris_pkg::GAIN_W-1:16];
  assign gcap      = (decayed > (ris_pkg::GAIN_W+1)'(ris_pkg::GAIN_ONE))
                   ? ris_pkg::GAIN_ONE : decayed[ris_pkg::GAIN_W-1:0];
  assign ch_sample  = $signed(item_q.samples[ch_q]);
  assign act_sample = $signed(item_q.samples[item_q.active]);

  // Active sample plus the scaled fade sum, then saturate
  always_comb begin
    mix = ris_pkg::MIX_W'(scaled_q >>> ris_pkg::FADE_SHIFT)
        + ris_pkg::MIX_W'(act_sample);
    if (mix > SAT_HI)      mix_sat = 16'sh7fff;
    else if (mix < SAT_LO) mix_sat = -16'sh8000;
    else                   mix_sat = mix[ris_pkg::SAMPLE_W-1:0];
  end

  // Walk the channels one at a time, reusing the same multipliers for each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ris_pkg::CHANNELS; i++) gain_q[i] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            item_q  <= pop_item_i;
            ch_q    <= '0;
            acc_q   <= '0;
            state_q <= pop_item_i.any_conn ? S_DECAY : S_OUT;
          end
        end
        S_DECAY: begin
          prod_q  <= {{ris_pkg::GAIN_W{1'b0}}, gain_q[ch_q]}
                   * {{ris_pkg::GAIN_W{1'b0}}, cfg_i.decay_multiplier};
          state_q <= S_TERM;
        end
        S_TERM: begin
          if (ch_q == item_q.active) begin
            gain_q[ch_q] <= ris_pkg::GAIN_ONE;
            term_q       <= '0;
          end else begin
            gain_q[ch_q] <= gcap;
            term_q       <= ch_sample * $signed({1'b0, gcap});
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_q + ris_pkg::ACC_W'(term_q);
          if (ch_q == ris_pkg::CH_W'(ris_pkg::CHANNELS - 1)) begin
            state_q <= S_FADE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_DECAY;
          end
        end
        S_FADE: begin
          scaled_q <= acc_q * $signed(item_q.fade);
          state_q  <= S_MIX;
        end
        S_MIX: begin
          held_q  <= mix_sat;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_mix_q   <= held_q;
            out_sel_q   <= item_q.active;
            out_blink_q <= item_q.blink;
            out_fired_q <= item_q.fired;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.mixed_sample     = out_mix_q;
  assign out_ch.selected_channel = 3'(out_sel_q);
  assign out_ch.blink_level      = out_blink_q;
  assign out_ch.trigger_fired    = out_fired_q;

endmodule

// ----- design/random_input_selector_with_fade_top.sv -----
// Random input selector with fade. Each input word carries eight channel
// samples, a connected mask, a gate, a fade control and a random word; each
// gives exactly one output word with the mix, the active channel, the blink
// level and a trigger flag. The front end runs the gate trigger and channel
// pick in the cycle a word arrives and can take a word every cycle until its
// two-deep queue is full. The mix engine walks the channels in turn with the
// same multipliers, decaying, weighting and accumulating each, then scales
// by the fade and saturates; a word with no channel connected skips the
// walk. The engine takes a new word only once the last is in its output
// register; a stalled output holds it. Write configuration only while idle.
module random_input_selector_with_fade_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ris_in_if.sink                           in_ch,
  ris_out_if.source                        out_ch,
  input  logic                             cfg_we_i,
  input  logic [ris_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ris_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  ris_pkg::ris_cfg_t  cfg_q;
  ris_pkg::ris_item_t push_item, pop_item;
  logic               push_valid, push_ready, pop_valid, pop_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_knob           <= '0;
      cfg_q.decay_multiplier    <= ris_pkg::GAIN_W'(65535);
      cfg_q.gate_low_threshold  <= 16'd205;
      cfg_q.gate_high_threshold <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ris_pkg::CFG_FADE_KNOB: cfg_q.fade_knob <= cfg_data_i[ris_pkg::KNOB_W-1:0];
        ris_pkg::CFG_DECAY:     cfg_q.decay_multiplier <= cfg_data_i[ris_pkg::GAIN_W-1:0];
        ris_pkg::CFG_GATE_LOW:  cfg_q.gate_low_threshold <= cfg_data_i[15:0];
        ris_pkg::CFG_GATE_HIGH: cfg_q.gate_high_threshold <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ris_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  ris_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ris_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_ch      (out_ch)
  );

endmodule
